FILE: sv/lbs_pkg.sv
// ---------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning vertex unit.
// ---------------------------------------------------------------------------
package lbs_pkg;

  // item kinds on the command port
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SKIN = 1'b1;

  // register index bit of the config port
  localparam logic REG_JOINT_COUNT = 1'b0;

  localparam int WORD_W      = 32;  // matrix word, Q16.16
  localparam int MAT_N       = 12;  // words per 3x4 matrix
  localparam int MAT_COLS    = 4;
  localparam int ELEM_W      = 4;   // element index within a matrix
  localparam int JOINT_W     = 8;   // packed joint index
  localparam int WGT_W       = 16;  // Q0.16 weight
  localparam int PACKED_INFL = 4;
  localparam int PROD_W      = 48;  // weight * word
  localparam int SQ_IN_W     = 62;  // sum of three squared 30-bit magnitudes
  localparam int SQ_STEPS    = 32;  // one root bit per stage
  localparam int ROOT_W      = 32;
  localparam int SMAG_W      = 30;  // scaled magnitude
  localparam int DIV_STEPS   = 15;  // one quotient bit per stage

  typedef logic signed [PROD_W-1:0] wprod_t;

  // matrix word write toward every lane copy of the store
  typedef struct packed {
    logic               en;
    logic [JOINT_W-1:0] joint;
    logic [ELEM_W-1:0]  elem;
    logic [WORD_W-1:0]  data;
  } wr_t;

endpackage

FILE: sv/linear_blend_skinning_vertex_unit.sv
// ---------------------------------------------------------------------------
// linear_blend_skinning_vertex_unit
// Blends up to four joint matrices per vertex, transforms position and
// normal, and normalizes the normal.
// A matrix word is written at its start edge and is seen by the next vertex.
// Throughput: one word per cycle, busy stays low; the root (32 stages) and
// divider (15 stages) pipelines set the latency. Results cannot be stalled.
// Reset: clears the pipeline valids and sets joint_count to 64; the joint
// store is not cleared and must be written before use.
// ---------------------------------------------------------------------------
module linear_blend_skinning_vertex_unit import lbs_pkg::*; #(
  parameter int MAX_JOINTS = 64,
  parameter int INFLUENCES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // command port
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [9:0]          in_load_slot,
  input  logic signed [31:0]  in_load_value,
  input  logic signed [31:0]  in_pos_x,
  input  logic signed [31:0]  in_pos_y,
  input  logic signed [31:0]  in_pos_z,
  input  logic signed [15:0]  in_nrm_x,
  input  logic signed [15:0]  in_nrm_y,
  input  logic signed [15:0]  in_nrm_z,
  input  logic [31:0]         in_joint_ids,
  input  logic [63:0]         in_weights,
  // result port
  output logic                out_valid,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_pos_z,
  output logic signed [15:0]  out_nrm_x,
  output logic signed [15:0]  out_nrm_y,
  output logic signed [15:0]  out_nrm_z,
  output logic                out_normal_degenerate,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int NLANES      = (INFLUENCES < PACKED_INFL) ? INFLUENCES : PACKED_INFL;
  localparam int STORE_DEPTH = MAX_JOINTS * MAT_N;
  localparam int MAG_DLY     = 2 + SQ_STEPS;
  localparam int SIDE_DLY    = MAG_DLY + DIV_STEPS;
  localparam int VLD_N       = 9 + SIDE_DLY;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][15:0] nrm;
  } vtx_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0]       neg;
    logic             deg;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -67'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [5:0] lead_one(input logic [49:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------- control
  logic acc;
  logic skin;
  logic [VLD_N-1:0] vld_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign skin = acc && (in_action == ACT_SKIN);

  // config register
  logic [6:0] joint_count_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_JOINT_COUNT) ? {25'b0, joint_count_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= 7'd64;
    end else if (cfg_wr && (paddr[2] == REG_JOINT_COUNT)) begin
      joint_count_r <= pwdata[6:0];
    end
  end

  // valid shift line, bit k marks a vertex in stage k
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLD_N-2:0], skin};
    end
  end

  // ---------------------------------------------------------------- store write
  logic [19:0] slot_mul;
  logic [6:0]  slot_joint;
  wr_t         wr;

  // slot / 12 by reciprocal, exact for 10-bit slots
  assign slot_mul   = 20'(in_load_slot) * 20'd683;
  assign slot_joint = slot_mul[19:13];

  assign wr.en    = acc && (in_action == ACT_LOAD) && (12'(in_load_slot) < 12'(STORE_DEPTH));
  assign wr.joint = {1'b0, slot_joint};
  assign wr.elem  = ELEM_W'(in_load_slot - (10'(slot_joint) * 10'd12));
  assign wr.data  = in_load_value;

  // ---------------------------------------------------------------- lanes
  logic [8:0] limit;
  wprod_t     lane_prod [NLANES][MAT_N];

  assign limit = (9'(joint_count_r) < 9'(MAX_JOINTS)) ? 9'(joint_count_r) : 9'(MAX_JOINTS);

  for (genvar j = 0; j < NLANES; j++) begin : g_lane
    logic [JOINT_W-1:0] id;
    logic [WGT_W-1:0]   wgt;
    logic               use_it;

    assign id     = in_joint_ids[JOINT_W*j +: JOINT_W];
    assign wgt    = in_weights[WGT_W*j +: WGT_W];
    assign use_it = skin && (wgt != '0) && ({1'b0, id} < limit);

    lbs_lane #(.MAX_JOINTS(MAX_JOINTS)) u_lane (
      .clk       (clk),
      .wr        (wr),
      .rd_id     (id),
      .rd_use    (use_it),
      .rd_weight (wgt),
      .prod_r    (lane_prod[j])
    );
  end

  // vertex payload delayed to the matrix stage
  vtx_t vtx_in;
  vtx_t vtx_r [4];

  assign vtx_in.pos = {in_pos_z, in_pos_y, in_pos_x};
  assign vtx_in.nrm = {in_nrm_z, in_nrm_y, in_nrm_x};

  always_ff @(posedge clk) begin
    vtx_r[0] <= vtx_in;
    for (int k = 1; k < 4; k++) begin
      vtx_r[k] <= vtx_r[k-1];
    end
  end

  // ---------------------------------------------------------------- merge
  logic signed [49:0] msum_r [MAT_N];
  logic signed [31:0] m_r    [MAT_N];

  always_ff @(posedge clk) begin
    for (int e = 0; e < MAT_N; e++) begin
      logic signed [49:0] s;
      s = '0;
      for (int l = 0; l < NLANES; l++) begin
        s = s + 50'(lane_prod[l][e]);
      end
      msum_r[e] <= s;
    end
  end

  // round half up to Q16.16 and saturate
  always_ff @(posedge clk) begin
    for (int e = 0; e < MAT_N; e++) begin
      m_r[e] <= sat32(67'((msum_r[e] + 50'sd32768) >>> 16));
    end
  end

  // ---------------------------------------------------------------- transform
  logic signed [63:0] pp_r  [3][3];
  logic signed [47:0] np_r  [3][3];
  logic signed [31:0] off_r [3];
  logic signed [31:0] off5_r[3];
  logic signed [65:0] ps_r  [3];
  logic signed [49:0] vs_r  [3];

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pp_r[r][c] <= m_r[r*MAT_COLS+c] * $signed(vtx_r[3].pos[c]);
        np_r[r][c] <= m_r[r*MAT_COLS+c] * $signed(vtx_r[3].nrm[c]);
      end
      off_r[r] <= m_r[r*MAT_COLS+3];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      ps_r[r]   <= 66'(pp_r[r][0]) + 66'(pp_r[r][1]) + 66'(pp_r[r][2]);
      vs_r[r]   <= 50'(np_r[r][0]) + 50'(np_r[r][1]) + 50'(np_r[r][2]);
      off5_r[r] <= off_r[r];
    end
  end

  // position finish, normal magnitudes and signs
  logic [2:0][31:0] pos6_r;
  logic [49:0]      mag6_r [3];
  logic [2:0]       neg6_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic signed [65:0] rnd;
      rnd = (ps_r[r] + 66'sd32768) >>> 16;
      pos6_r[r] <= sat32(67'(rnd) + 67'(off5_r[r]));
      mag6_r[r] <= (vs_r[r] < 0) ? 50'(-vs_r[r]) : 50'(vs_r[r]);
      neg6_r[r] <= vs_r[r] < 0;
    end
  end

  // leading one of the largest magnitude
  logic [49:0]      or6;
  logic [5:0]       lead7_r;
  logic             deg7_r;
  logic [49:0]      mag7_r [3];
  logic [2:0][31:0] pos7_r;
  logic [2:0]       neg7_r;

  assign or6 = mag6_r[0] | mag6_r[1] | mag6_r[2];

  always_ff @(posedge clk) begin
    lead7_r <= lead_one(or6);
    deg7_r  <= or6 == '0;
    mag7_r  <= mag6_r;
    pos7_r  <= pos6_r;
    neg7_r  <= neg6_r;
  end

  // scale so the largest magnitude lands in [2^29, 2^30)
  logic [SMAG_W-1:0] smag8_r [3];
  side_t             side8_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      logic [78:0] wide;
      wide = {mag7_r[r], 29'b0} >> lead7_r;
      smag8_r[r] <= wide[SMAG_W-1:0];
    end
    side8_r.pos <= pos7_r;
    side8_r.neg <= neg7_r;
    side8_r.deg <= deg7_r;
  end

  // squares and their sum
  logic [59:0]        sqr_r [3];
  logic [SQ_IN_W-1:0] sq_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      sqr_r[r] <= smag8_r[r] * smag8_r[r];
    end
    sq_r <= SQ_IN_W'(sqr_r[0]) + SQ_IN_W'(sqr_r[1]) + SQ_IN_W'(sqr_r[2]);
  end

  // ---------------------------------------------------------------- normalize
  logic [ROOT_W-1:0] len;

  lbs_sqrt u_sqrt (
    .clk  (clk),
    .rad  (sq_r),
    .root (len)
  );

  // magnitudes wait for the root, sideband waits for the quotient
  logic [SMAG_W-1:0] mag_d  [MAG_DLY][3];
  side_t             side_d [SIDE_DLY];

  always_ff @(posedge clk) begin
    mag_d[0]  <= smag8_r;
    side_d[0] <= side8_r;
    for (int k = 1; k < MAG_DLY; k++) begin
      mag_d[k] <= mag_d[k-1];
    end
    for (int k = 1; k < SIDE_DLY; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  logic [DIV_STEPS-1:0] quo [3];

  for (genvar r = 0; r < 3; r++) begin : g_div
    lbs_div u_div (
      .clk (clk),
      .mag (mag_d[MAG_DLY-1][r]),
      .len (len),
      .quo (quo[r])
    );
  end

  // ---------------------------------------------------------------- output word
  side_t side_o;
  logic [2:0][15:0] nrm_o;

  assign side_o = side_d[SIDE_DLY-1];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (side_o.deg) begin
        nrm_o[r] = '0;
      end else if (side_o.neg[r]) begin
        nrm_o[r] = 16'(-{1'b0, quo[r]});
      end else begin
        nrm_o[r] = {1'b0, quo[r]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[VLD_N-1];
    end
  end

  always_ff @(posedge clk) begin
    out_pos_x             <= side_o.pos[0];
    out_pos_y             <= side_o.pos[1];
    out_pos_z             <= side_o.pos[2];
    out_nrm_x             <= nrm_o[0];
    out_nrm_y             <= nrm_o[1];
    out_nrm_z             <= nrm_o[2];
    out_normal_degenerate <= side_o.deg;
  end

endmodule

FILE: sv/lbs_lane.sv
// ---------------------------------------------------------------------------
// lbs_lane
// One influence lane: its own copy of the joint store, split in one bank per
// matrix element, and the weight multipliers for all twelve elements.
// ---------------------------------------------------------------------------
module lbs_lane import lbs_pkg::*; #(
  parameter int MAX_JOINTS = 64
) (
  input  logic               clk,
  input  wr_t                wr,
  input  logic [JOINT_W-1:0] rd_id,
  input  logic               rd_use,
  input  logic [WGT_W-1:0]   rd_weight,
  output wprod_t             prod_r [MAT_N]
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic             use_r;
  logic [WGT_W-1:0] wgt_r;

  // lane enable and weight ride along with the store read
  always_ff @(posedge clk) begin
    use_r <= rd_use;
    wgt_r <= rd_weight;
  end

  for (genvar e = 0; e < MAT_N; e++) begin : g_bank
    logic [WORD_W-1:0]   mem [MAX_JOINTS];
    logic [WORD_W-1:0]   word_r;
    logic signed [48:0]  mul;

    // bank write and registered read
    always_ff @(posedge clk) begin
      if (wr.en && (wr.elem == ELEM_W'(e))) begin
        mem[wr.joint[JW-1:0]] <= wr.data;
      end
      word_r <= mem[rd_id[JW-1:0]];
    end

    // weighted element, zero for a skipped influence
    assign mul = $signed({1'b0, wgt_r}) * $signed(word_r);

    always_ff @(posedge clk) begin
      prod_r[e] <= use_r ? mul[PROD_W-1:0] : '0;
    end
  end

endmodule

FILE: sv/lbs_sqrt.sv
// ---------------------------------------------------------------------------
// lbs_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module lbs_sqrt import lbs_pkg::*; (
  input  logic               clk,
  input  logic [SQ_IN_W-1:0] rad,
  output logic [ROOT_W-1:0]  root
);

  logic [63:0] x_r [1:SQ_STEPS];
  logic [63:0] r_r [1:SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] cur_x;
    logic [63:0] cur_r;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign cur_x = 64'(rad);
      assign cur_r = '0;
    end else begin : g_next
      assign cur_x = x_r[i];
      assign cur_r = r_r[i];
    end

    assign trial = cur_r + BIT;

    // restoring root step
    always_ff @(posedge clk) begin
      if (cur_x >= trial) begin
        x_r[i+1] <= cur_x - trial;
        r_r[i+1] <= (cur_r >> 1) + BIT;
      end else begin
        x_r[i+1] <= cur_x;
        r_r[i+1] <= cur_r >> 1;
      end
    end
  end

  assign root = r_r[SQ_STEPS][ROOT_W-1:0];

endmodule

FILE: sv/lbs_div.sv
// ---------------------------------------------------------------------------
// lbs_div
// Pipelined rounded division mag * 16384 / len, one quotient bit per stage.
// ---------------------------------------------------------------------------
module lbs_div import lbs_pkg::*; (
  input  logic                 clk,
  input  logic [SMAG_W-1:0]    mag,
  input  logic [ROOT_W-1:0]    len,
  output logic [DIV_STEPS-1:0] quo
);

  localparam int NUM_W = SMAG_W + 14 + 2;

  logic [ROOT_W-1:0]    rem_r [1:DIV_STEPS];
  logic [DIV_STEPS-1:0] low_r [1:DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r   [1:DIV_STEPS];
  logic [ROOT_W-1:0]    d_r   [1:DIV_STEPS];

  // numerator with half the divisor added for rounding
  logic [NUM_W-1:0] num;
  assign num = NUM_W'({mag, 14'b0}) + NUM_W'(len >> 1);

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [ROOT_W-1:0]    cur_rem;
    logic [DIV_STEPS-1:0] cur_low;
    logic [DIV_STEPS-1:0] cur_q;
    logic [ROOT_W-1:0]    cur_d;
    logic [ROOT_W:0]      trial;
    logic                 ge;

    if (i == 0) begin : g_first
      assign cur_rem = ROOT_W'(num[NUM_W-1:DIV_STEPS]);
      assign cur_low = num[DIV_STEPS-1:0];
      assign cur_q   = '0;
      assign cur_d   = len;
    end else begin : g_next
      assign cur_rem = rem_r[i];
      assign cur_low = low_r[i];
      assign cur_q   = q_r[i];
      assign cur_d   = d_r[i];
    end

    assign trial = {cur_rem, cur_low[DIV_STEPS-1]};
    assign ge    = trial >= {1'b0, cur_d};

    // restoring division step
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? ROOT_W'(trial - {1'b0, cur_d}) : trial[ROOT_W-1:0];
      low_r[i+1] <= cur_low << 1;
      q_r[i+1]   <= {cur_q[DIV_STEPS-2:0], ge};
      d_r[i+1]   <= cur_d;
    end
  end

  assign quo = q_r[DIV_STEPS];

endmodule

FILE: bench/tb_linear_blend_skinning_vertex_unit.sv
// ---------------------------------------------------------------------------
// tb_linear_blend_skinning_vertex_unit
// Self-checking bench for the skinning unit: loads joint matrices, skins
// directed and random vertices under several joint counts, and compares each
// skinned vertex with a bit-accurate fixed-point predictor.
// ---------------------------------------------------------------------------
module tb_linear_blend_skinning_vertex_unit;
  import lbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = 64;
  localparam int DEPTH = NJ * 12;
  localparam int LATENCY = 58;
  localparam int WATCHDOG = 4000;
  localparam int LOW_JOINTS = 16;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic deg;
  } skinned_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = ACT_LOAD;
  logic [9:0] in_load_slot = '0;
  logic signed [31:0] in_load_value = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;
  logic [31:0] in_joint_ids = '0;
  logic [63:0] in_weights = '0;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
  logic out_normal_degenerate;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  linear_blend_skinning_vertex_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_load_slot(in_load_slot),
    .in_load_value(in_load_value),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_joint_ids(in_joint_ids), .in_weights(in_weights),
    .out_valid(out_valid), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z), .out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y),
    .out_nrm_z(out_nrm_z), .out_normal_degenerate(out_normal_degenerate),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] joint_mats [DEPTH];
  bit written [DEPTH];
  int unsigned joint_limit = 64;
  skinned_t expected_verts [$];
  int errors = 0;
  int vertices_seen = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // skin one vertex from the current matrix store
  function automatic skinned_t skin_vertex(logic signed [31:0] p [3],
      logic signed [15:0] n [3], logic [31:0] ids, logic [63:0] wts);
    skinned_t res;
    longint acc [12];
    longint m [12];
    longint v [3];
    longint unsigned mag [3];
    longint unsigned big, sq, len, q;
    longint hi, lo, prod, h, w;
    int id;
    for (int c = 0; c < 12; c++) acc[c] = 0;
    for (int j = 0; j < PACKED_INFL; j++) begin
      id = ids[8*j +: 8];
      w = wts[16*j +: 16];
      if (w != 0 && id < joint_limit)
        for (int c = 0; c < 12; c++)
          acc[c] += w * longint'($signed(joint_mats[id*12 + c]));
    end
    for (int c = 0; c < 12; c++) m[c] = clamp32(fshr(acc[c] + 32768, 16));
    for (int r = 0; r < 3; r++) begin
      hi = 0;
      lo = 0;
      for (int c = 0; c < 3; c++) begin
        prod = m[r*4 + c] * longint'(p[c]);
        h = fshr(prod, 16);
        hi += h;
        lo += prod - h * 65536;
      end
      hi += fshr(lo + 32768, 16) + m[r*4 + 3];
      hi = clamp32(hi);
      if (r == 0) res.px = hi[31:0];
      else if (r == 1) res.py = hi[31:0];
      else res.pz = hi[31:0];
    end
    big = 0;
    for (int r = 0; r < 3; r++) begin
      v[r] = 0;
      for (int c = 0; c < 3; c++) v[r] += m[r*4 + c] * longint'(n[c]);
      mag[r] = v[r] < 0 ? -v[r] : v[r];
      if (mag[r] > big) big = mag[r];
    end
    res.deg = (big == 0);
    res.nx = '0;
    res.ny = '0;
    res.nz = '0;
    if (!res.deg) begin
      while (big >= (64'd1 << 30)) begin
        big >>= 1;
        for (int r = 0; r < 3; r++) mag[r] >>= 1;
      end
      while (big < (64'd1 << 29)) begin
        big <<= 1;
        for (int r = 0; r < 3; r++) mag[r] <<= 1;
      end
      sq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      len = root64(sq);
      for (int r = 0; r < 3; r++) begin
        q = (mag[r] * 16384 + len / 2) / len;
        h = v[r] < 0 ? -longint'(q) : longint'(q);
        if (r == 0) res.nx = h[15:0];
        else if (r == 1) res.ny = h[15:0];
        else res.nz = h[15:0];
      end
    end
    return res;
  endfunction

  // random gap before a word
  task automatic maybe_gap();
    int n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // send one word and predict its result
  task automatic send_word(logic act, logic [9:0] slot, logic [31:0] val,
      logic signed [31:0] p [3], logic signed [15:0] n [3],
      logic [31:0] ids, logic [63:0] wts);
    maybe_gap();
    start <= 1'b1;
    in_action <= act;
    in_load_slot <= slot;
    in_load_value <= val;
    in_pos_x <= p[0];
    in_pos_y <= p[1];
    in_pos_z <= p[2];
    in_nrm_x <= n[0];
    in_nrm_y <= n[1];
    in_nrm_z <= n[2];
    in_joint_ids <= ids;
    in_weights <= wts;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (act == ACT_LOAD) begin
      if (slot < DEPTH) begin
        joint_mats[slot] = val;
        written[slot] = 1'b1;
      end
    end else begin
      expected_verts.push_back(skin_vertex(p, n, ids, wts));
    end
  endtask

  task automatic load_word(int slot, logic [31:0] val);
    logic signed [31:0] p [3];
    logic signed [15:0] n [3];
    foreach (p[i]) p[i] = $urandom;
    foreach (n[i]) n[i] = $urandom;
    send_word(ACT_LOAD, slot[9:0], val, p, n, $urandom, {$urandom, $urandom});
  endtask

  // a joint is usable once all twelve of its words were written
  function automatic bit joint_ready(int id);
    for (int e = 0; e < 12; e++)
      if (!written[id*12 + e]) return 1'b0;
    return 1'b1;
  endfunction

  // joint ids may point anywhere except unwritten joints under the limit
  function automatic logic [31:0] pick_ids();
    logic [31:0] ids;
    int id;
    for (int j = 0; j < 4; j++) begin
      do id = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, 63);
      while (id < joint_limit && !joint_ready(id));
      ids[8*j +: 8] = id;
    end
    return ids;
  endfunction

  task automatic skin_random(int mode);
    logic signed [31:0] p [3];
    logic signed [15:0] n [3];
    logic [63:0] wts;
    foreach (p[i]) p[i] = (mode == 0) ? $urandom : $signed($urandom_range(0, 'h7ffff))
                                                   - 32'sh40000;
    foreach (n[i]) n[i] = (mode == 0) ? $urandom : $signed($urandom_range(0, 'h8000))
                                                   - 16'sh4000;
    for (int j = 0; j < 4; j++)
      case ($urandom_range(0, 5))
        0: wts[16*j +: 16] = '0;
        1: wts[16*j +: 16] = 16'hffff;
        default: wts[16*j +: 16] = $urandom;
      endcase
    send_word(ACT_SKIN, '0, $urandom, p, n, pick_ids(), wts);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drain, then settle before touching the register
  task automatic set_joint_count(int cnt);
    start <= 1'b0;
    while (expected_verts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_write(3'(4 * REG_JOINT_COUNT), cnt);
    joint_limit = cnt < NJ ? cnt : NJ;
  endtask

  // low joints and the top joint get full matrices before any vertex reads them
  task automatic test_matrix_load();
    logic [31:0] val;
    for (int j = 0; j < NJ; j++) begin
      if (j < LOW_JOINTS || j == NJ - 1) begin
        for (int e = 0; e < 12; e++) begin
          case ($urandom_range(0, 9))
            0: val = 32'h7fffffff;
            1: val = 32'h80000000;
            2, 3: val = $urandom;
            default: val = $signed($urandom_range(0, 'h3ffff)) - 32'sh20000;
          endcase
          load_word(j * 12 + e, val);
        end
      end
    end
    load_word(DEPTH, 32'h12345678);
    load_word(1023, 32'hdeadbeef);
  endtask

  task automatic test_directed();
    logic signed [31:0] p [3];
    logic signed [15:0] n [3];
    // identity matrix on joint 0
    for (int e = 0; e < 12; e++) load_word(e, (e % 5 == 0) ? 32'h10000 : 32'h0);
    p = '{32'h7fffffff, 32'h80000000, 32'h10000};
    n = '{16'h7fff, 16'h8000, 16'h0};
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0, 64'hffff);
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0, 64'h0);
    n = '{16'h0, 16'h0, 16'h0};
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0, 64'h8000);
    n = '{16'h4000, 16'h0, 16'h0};
    send_word(ACT_SKIN, '0, '0, p, n, 32'hffff_ff40, 64'hffff_ffff_ffff_ffff);
    send_word(ACT_SKIN, '0, '0, p, n, 32'h3f_01_00_00, 64'hffff_ffff_8000_0001);
    p = '{32'h0, 32'hffffffff, 32'h1};
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0302_0100, 64'h4000_4000_4000_4000);
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0, 64'hffff_0000_0000_0000);
    // saturating blend on joint 1
    for (int e = 0; e < 12; e++) load_word(12 + e, e[0] ? 32'h7fffffff : 32'h80000000);
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0101_0101, 64'hffff_ffff_ffff_ffff);
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    n = '{16'h7fff, 16'h7fff, 16'h7fff};
    send_word(ACT_SKIN, '0, '0, p, n, 32'h0001_0001, 64'hffff_ffff_ffff_ffff);
  endtask

  task automatic test_random_vertices(int count);
    for (int i = 0; i < count; i++)
      if ($urandom_range(0, 9) == 0)
        load_word($urandom_range(0, 1023), $urandom);
      else
        skin_random($urandom_range(0, 1));
  endtask

  task automatic test_joint_counts();
    int counts [4] = '{0, 1, 37, 127};
    foreach (counts[k]) begin
      set_joint_count(counts[k]);
      test_random_vertices(40);
    end
    set_joint_count(64);
  endtask

  // result checker
  always @(posedge clk) begin
    skinned_t exp_v;
    if (rst_n && out_valid) begin
      vertices_seen++;
      if (expected_verts.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex result", $time);
      end else begin
        exp_v = expected_verts.pop_front();
        if (exp_v.px !== out_pos_x || exp_v.py !== out_pos_y || exp_v.pz !== out_pos_z) begin
          errors++;
          $display("%0t: pos mismatch exp %h %h %h got %h %h %h", $time,
                   exp_v.px, exp_v.py, exp_v.pz, out_pos_x, out_pos_y, out_pos_z);
        end
        if (exp_v.nx !== out_nrm_x || exp_v.ny !== out_nrm_y || exp_v.nz !== out_nrm_z) begin
          errors++;
          $display("%0t: normal mismatch exp %h %h %h got %h %h %h", $time,
                   exp_v.nx, exp_v.ny, exp_v.nz, out_nrm_x, out_nrm_y, out_nrm_z);
        end
        if (exp_v.deg !== out_normal_degenerate) begin
          errors++;
          $display("%0t: degenerate flag mismatch exp %b got %b", $time,
                   exp_v.deg, out_normal_degenerate);
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_matrix_load();
    test_directed();
    test_joint_counts();
    test_random_vertices(150);
    gaps_on = 1'b0;
    test_random_vertices(80);
    start <= 1'b0;
    while (expected_verts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Covered %0d skinned vertices over joint counts 0, 1, 37, 64, 127", vertices_seen);
    $display("with matrix loads, out-of-range slots and skipped influences");
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
